FILE: rtl/core/triangle_primitive_assembly_core_defines.svh
// Assertion macros shared by the core RTL.
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLY_CORE_DEFINES_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLY_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while in reset.
`define TPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/core/tpa_pkg.sv
`timescale 1ns / 1ps

package tpa_pkg;

  typedef enum logic [1:0] {
    ModeStrip = 2'd0,
    ModeList  = 2'd1,
    ModeQuad  = 2'd2,
    ModeFan   = 2'd3
  } prim_mode_e;

  localparam int unsigned RegPrimMode    = 0;
  localparam int unsigned RegVertexCount = 1;

  localparam int unsigned TriFifoDepth = 8;
  localparam int unsigned TriFifoPtrW  = 3;

  // triangles produced by one index: second only ever comes with first
  typedef struct packed {
    logic first;
    logic second;
  } emit_t;

endpackage

FILE: rtl/core/tpa_index_if.sv
`timescale 1ns / 1ps

interface tpa_index_if #(
  parameter int INDEX_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] index_value;
  logic                  stream_start;

  modport source (output valid, output index_value, output stream_start, input ready);
  modport sink   (input valid, input index_value, input stream_start, output ready);
endinterface

FILE: rtl/core/tpa_tri_if.sv
`timescale 1ns / 1ps

interface tpa_tri_if #(
  parameter int INDEX_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] vert_a;
  logic [INDEX_BITS-1:0] vert_b;
  logic [INDEX_BITS-1:0] vert_c;
  logic                  last_of_run;

  modport source (output valid, output vert_a, output vert_b, output vert_c,
                  output last_of_run, input ready);
  modport sink   (input valid, input vert_a, input vert_b, input vert_c,
                  input last_of_run, output ready);
endinterface

FILE: rtl/core/tpa_assembler.sv
`timescale 1ns / 1ps
`include "triangle_primitive_assembly_core_defines.svh"

module tpa_assembler #(
  parameter int INDEX_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tpa_pkg::prim_mode_e      mode_i,
  input  logic [INDEX_BITS:0]      vertex_count_i,
  input  logic                     in_valid_i,
  input  logic [INDEX_BITS-1:0]    index_i,
  input  logic                     start_i,
  output logic                     busy_o,
  output tpa_pkg::emit_t           emit_o,
  output logic [3*INDEX_BITS:0]    tri0_o,
  output logic [3*INDEX_BITS:0]    tri1_o
);

  logic                  stage_v_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic                  start_q;

  logic [INDEX_BITS-1:0] older_q, older_d, newer_q, newer_d, root_q, root_d;
  logic                  rir_q, rir_d, parity_q, parity_d;
  logic [1:0]            gp_q, gp_d;

  logic [INDEX_BITS-1:0] older_c, newer_c, root_c;
  logic                  rir_c, parity_c;
  logic [1:0]            gp_c;
  logic                  idx_lt, older_lt, newer_lt, root_lt;
  logic                  strip_ok, quad_ok, fan_ok;
  tpa_pkg::emit_t        emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      idx_q   <= index_i;
      start_q <= start_i;
    end
  end

  // mesh restart clears history before the index is used
  always_comb begin
    older_c  = start_q ? '0 : older_q;
    newer_c  = start_q ? '0 : newer_q;
    root_c   = start_q ? '0 : root_q;
    rir_c    = start_q ? 1'b0 : rir_q;
    parity_c = start_q ? 1'b0 : parity_q;
    gp_c     = start_q ? 2'd0 : gp_q;
  end

  assign idx_lt   = {1'b0, idx_q}   < vertex_count_i;
  assign older_lt = {1'b0, older_c} < vertex_count_i;
  assign newer_lt = {1'b0, newer_c} < vertex_count_i;
  assign root_lt  = {1'b0, root_c}  < vertex_count_i;

  assign strip_ok = older_lt && newer_lt && idx_lt && (older_c != newer_c) &&
                    (newer_c != idx_q) && (older_c != idx_q);
  assign quad_ok  = root_lt && older_lt && newer_lt && idx_lt;
  assign fan_ok   = rir_c && root_lt && newer_lt && idx_lt && (root_c != newer_c) &&
                    (newer_c != idx_q) && (root_c != idx_q);

  always_comb begin
    older_d  = older_c;
    newer_d  = newer_c;
    root_d   = root_c;
    rir_d    = rir_c;
    parity_d = parity_c;
    gp_d     = gp_c;
    emit     = '0;
    tri0_o   = {older_c, newer_c, idx_q, 1'b1};
    tri1_o   = {root_c, newer_c, idx_q, 1'b1};
    case (mode_i)
      tpa_pkg::ModeStrip: begin
        if (gp_c[1]) begin
          emit.first = strip_ok;
          if (parity_c) begin
            tri0_o = {older_c, idx_q, newer_c, 1'b1};
          end
          parity_d = ~parity_c;
          gp_d     = 2'd2;
        end else begin
          gp_d = gp_c + 2'd1;
        end
        older_d = newer_c;
        newer_d = idx_q;
      end
      tpa_pkg::ModeList: begin
        if (gp_c[1]) begin
          emit.first = strip_ok;
          gp_d       = 2'd0;
        end else begin
          if (gp_c == 2'd0) begin
            older_d = idx_q;
          end else begin
            newer_d = idx_q;
          end
          gp_d = gp_c + 2'd1;
        end
      end
      tpa_pkg::ModeQuad: begin
        if (gp_c == 2'd3) begin
          emit.first  = quad_ok;
          emit.second = quad_ok;
          tri0_o      = {root_c, older_c, newer_c, 1'b0};
          tri1_o      = {root_c, newer_c, idx_q, 1'b1};
          gp_d        = 2'd0;
        end else begin
          case (gp_c)
            2'd0:    root_d  = idx_q;
            2'd1:    older_d = idx_q;
            default: newer_d = idx_q;
          endcase
          gp_d = gp_c + 2'd1;
        end
      end
      tpa_pkg::ModeFan: begin
        if (gp_c == 2'd0) begin
          root_d = idx_q;
          rir_d  = idx_lt;
          gp_d   = 2'd1;
        end else if (gp_c == 2'd1) begin
          newer_d = idx_q;
          gp_d    = 2'd2;
        end else begin
          emit.first = fan_ok;
          tri0_o     = {root_c, newer_c, idx_q, 1'b1};
          newer_d    = idx_q;
          gp_d       = 2'd2;
        end
      end
      default: begin
        emit = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q  <= '0;
      newer_q  <= '0;
      root_q   <= '0;
      rir_q    <= 1'b0;
      parity_q <= 1'b0;
      gp_q     <= 2'd0;
    end else if (stage_v_q) begin
      older_q  <= older_d;
      newer_q  <= newer_d;
      root_q   <= root_d;
      rir_q    <= rir_d;
      parity_q <= parity_d;
      gp_q     <= gp_d;
    end
  end

  assign busy_o        = stage_v_q;
  assign emit_o.first  = stage_v_q & emit.first;
  assign emit_o.second = stage_v_q & emit.second;

  `TPA_ASSERT_IMP(a_second_needs_first, clk_i, rst_ni, emit_o.second, emit_o.first)
  `TPA_ASSERT_IMP(a_second_only_quad, clk_i, rst_ni, emit_o.second,
                  mode_i == tpa_pkg::ModeQuad)
  `TPA_ASSERT_NXT(a_restart_position, clk_i, rst_ni, stage_v_q && start_q, gp_q == 2'd1)

endmodule

FILE: rtl/core/tpa_tri_fifo.sv
`timescale 1ns / 1ps
`include "triangle_primitive_assembly_core_defines.svh"

module tpa_tri_fifo #(
  parameter int INDEX_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tpa_pkg::emit_t                   emit_i,
  input  logic [3*INDEX_BITS:0]            tri0_i,
  input  logic [3*INDEX_BITS:0]            tri1_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [3*INDEX_BITS:0]            out_data_o,
  output logic [tpa_pkg::TriFifoPtrW:0]    count_o
);

  localparam int unsigned PtrW  = tpa_pkg::TriFifoPtrW;
  localparam int unsigned Depth = tpa_pkg::TriFifoDepth;

  logic [3*INDEX_BITS:0] mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [PtrW:0]         count_q, count_d;
  logic [1:0]            push_n;
  logic                  pop;

  assign push_n    = {1'b0, emit_i.first} + {1'b0, emit_i.second};
  assign pop       = out_valid_o & out_ready_i;
  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  assign wr_ptr_d = wr_ptr_q + {{(PtrW-2){1'b0}}, push_n};
  assign rd_ptr_d = rd_ptr_q + {{(PtrW-1){1'b0}}, pop};
  assign count_d  = count_q + {{(PtrW-1){1'b0}}, push_n} - {{PtrW{1'b0}}, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.first) begin
      mem_q[wr_ptr_q] <= tri0_i;
    end
    if (emit_i.second) begin
      mem_q[wr_ptr_nx] <= tri1_i;
    end
  end

  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = count_q;

  `TPA_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_n != 2'd0,
                  ({1'b0, count_q} + {{PtrW{1'b0}}, push_n}) <= (PtrW+2)'(Depth))
  `TPA_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= (PtrW+1)'(Depth))
  `TPA_ASSERT_NXT(a_pop_moves_head, clk_i, rst_ni, pop, rd_ptr_q == $past(rd_ptr_q) + 1'b1)

endmodule

FILE: rtl/core/triangle_primitive_assembly_core.sv
`timescale 1ns / 1ps

// Triangle assembly from a vertex index stream: one index is taken per clock,
// back to back while the input is ready, in strip, list, quad-list or fan mode
// as set in prim_mode, and each triangle leaves as one beat (quad mode gives
// two beats per four indices, last_of_run marking the second). An index passes
// an input register and is assembled in the next cycle; its triangles are
// written into an 8-entry queue whose head drives the output. The input holds
// off when the queue, with two entries kept for an index in flight, has fewer
// than two free entries, i.e. when the consumer stalls.
// Registers: prim_mode at byte 0x0, vertex_count at 0x4 (0x8 when
// INDEX_BITS is 32 or more); write them only while the block is idle.
module triangle_primitive_assembly_core #(
  parameter  int INDEX_BITS = 16,
  localparam int DataW      = (INDEX_BITS >= 32) ? 64 : 32,
  localparam int AddrW      = (DataW == 64) ? 4 : 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tpa_index_if.sink        idx_in,
  tpa_tri_if.source        tri_out,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int unsigned PtrW = tpa_pkg::TriFifoPtrW;
  localparam logic [PtrW+1:0] RoomLimit = (PtrW+2)'(tpa_pkg::TriFifoDepth - 2);

  tpa_pkg::prim_mode_e   mode_q;
  logic [INDEX_BITS:0]   vc_q;
  logic                  wr_en;
  logic                  reg_sel;
  logic                  busy;
  tpa_pkg::emit_t        emit;
  logic [3*INDEX_BITS:0] tri_first, tri_second, head;
  logic [PtrW:0]         fifo_count;
  logic                  in_accept;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[AddrW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tpa_pkg::ModeStrip;
      vc_q   <= '0;
    end else if (wr_en) begin
      if (reg_sel == 1'(tpa_pkg::RegPrimMode)) begin
        mode_q <= tpa_pkg::prim_mode_e'(pwdata[1:0]);
      end else begin
        vc_q <= pwdata[INDEX_BITS:0];
      end
    end
  end

  assign prdata = (reg_sel == 1'(tpa_pkg::RegVertexCount)) ? DataW'(vc_q) : DataW'(mode_q);

  assign idx_in.ready = ({1'b0, fifo_count} + {{PtrW{1'b0}}, busy, 1'b0}) <= RoomLimit;
  assign in_accept    = idx_in.valid & idx_in.ready;

  tpa_assembler #(
    .INDEX_BITS(INDEX_BITS)
  ) u_assembler (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .vertex_count_i (vc_q),
    .in_valid_i     (in_accept),
    .index_i        (idx_in.index_value),
    .start_i        (idx_in.stream_start),
    .busy_o         (busy),
    .emit_o         (emit),
    .tri0_o         (tri_first),
    .tri1_o         (tri_second)
  );

  tpa_tri_fifo #(
    .INDEX_BITS(INDEX_BITS)
  ) u_tri_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .tri0_i      (tri_first),
    .tri1_i      (tri_second),
    .out_valid_o (tri_out.valid),
    .out_ready_i (tri_out.ready),
    .out_data_o  (head),
    .count_o     (fifo_count)
  );

  assign tri_out.vert_a      = head[3*INDEX_BITS:2*INDEX_BITS+1];
  assign tri_out.vert_b      = head[2*INDEX_BITS:INDEX_BITS+1];
  assign tri_out.vert_c      = head[INDEX_BITS:1];
  assign tri_out.last_of_run = head[0];

endmodule
